// ===== hdl/lhp_pkg.sv =====
// Package for the latency histogram: request/response types, codes and limits.
// Used by latency_histogram_percentiles; lhp_ram does not import it.
`default_nettype none
package lhp_pkg;

  localparam int TICK_W  = 31;
  localparam int COUNT_W = 40;
  localparam int SUM_W   = 63;
  localparam int SEL_W   = 7;
  localparam int IDX_W   = 10;

  // request kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_CLOSE  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_LOAD   = 2'd3;

  // statistic selectors
  localparam logic [SEL_W-1:0] SEL_MIN   = 7'd0;
  localparam logic [SEL_W-1:0] SEL_MAX   = 7'd100;
  localparam logic [SEL_W-1:0] SEL_P999  = 7'd101;
  localparam logic [SEL_W-1:0] SEL_P9999 = 7'd102;

  // percentile store slots (slot 1..99 hold p1..p99)
  localparam int PCT_DEPTH = 102;
  localparam int PCT_AW    = 7;
  localparam logic [PCT_AW-1:0] SLOT_FIRST = 7'd1;
  localparam logic [PCT_AW-1:0] SLOT_P999  = 7'd100;
  localparam logic [PCT_AW-1:0] SLOT_P9999 = 7'd101;

  // scaled threshold factors
  localparam logic [13:0] MUL_PCT   = 14'd100;
  localparam logic [13:0] MUL_999   = 14'd999;
  localparam logic [13:0] MUL_1000  = 14'd1000;
  localparam logic [13:0] MUL_9999  = 14'd9999;
  localparam logic [13:0] MUL_10000 = 14'd10000;

  localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  // running statistics scopes
  localparam int SC_OPEN = 0;
  localparam int SC_LAST = 1;
  localparam int SC_ALL  = 2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TICK_W-1:0] sample_ticks;
    logic [IDX_W-1:0]  bucket_index;
    logic [TICK_W-1:0] ceiling_value;
    logic [SEL_W-1:0]  statistic_select;
    logic              scope_all;
  } lhp_req_t;

  typedef struct packed {
    logic [TICK_W-1:0]  stat_ticks;
    logic [COUNT_W-1:0] sample_count;
    logic [SUM_W-1:0]   tick_sum;
    logic [SUM_W-1:0]   tick_square_sum;
  } lhp_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/lhp_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module lhp_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 40,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/latency_histogram_percentiles.sv =====
// Latency histogram with per-epoch and all-time percentiles; uses lhp_pkg, lhp_ram.
// One request at a time. A sample scans the ceilings in order for its bucket, then
//   increments that bucket's count; a close, and the first all-time read, walk every
//   bucket to find the percentiles, limited by the one-read-per-cycle bucket memories.
// Reset: synchronous; a clearing pass over max(BUCKET_CNT,102) addresses zeroes the count
//   and percentile memories before the first request is taken.
`default_nettype none
module latency_histogram_percentiles
  import lhp_pkg::*;
#(
  parameter int BUCKET_CNT = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lhp_req_t in_req,
  output logic          out_valid,
  input  wire logic     out_ready,
  output lhp_rsp_t      out_rsp
);

  localparam int AW      = $clog2(BUCKET_CNT);
  localparam int CLR_LEN = (BUCKET_CNT > PCT_DEPTH) ? BUCKET_CNT : PCT_DEPTH;
  localparam int CLW     = $clog2(CLR_LEN);
  localparam logic [AW-1:0]  IDX_LAST = AW'(BUCKET_CNT - 1);
  localparam logic [CLW-1:0] CLR_LAST = CLW'(CLR_LEN - 1);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_SRCH_RD   = 4'd2;
  localparam logic [3:0] S_SRCH_CMP  = 4'd3;
  localparam logic [3:0] S_INC_RD    = 4'd4;
  localparam logic [3:0] S_INC_WR    = 4'd5;
  localparam logic [3:0] S_WALK_RD   = 4'd6;
  localparam logic [3:0] S_WALK_LD   = 4'd7;
  localparam logic [3:0] S_WALK_TEST = 4'd8;
  localparam logic [3:0] S_STAT_RD   = 4'd9;
  localparam logic [3:0] S_STAT_OUT  = 4'd10;

  logic [3:0]         state_r, state_nxt;
  logic [CLW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [PCT_AW-1:0]  p_r, p_nxt;
  logic [COUNT_W-1:0] sub_r, sub_nxt;
  logic [COUNT_W-1:0] wc_r, wc_nxt;
  logic [TICK_W-1:0]  ceil_r, ceil_nxt;
  logic               walk_tot_r, walk_tot_nxt;
  logic               frozen_r, frozen_nxt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;
  logic [61:0]        sq_r, sq_nxt;
  logic [SEL_W-1:0]   sel_r, sel_nxt;
  logic               scope_r, scope_nxt;
  logic               out_valid_r, out_valid_nxt;
  lhp_rsp_t           out_rsp_r, out_rsp_nxt;

  logic [COUNT_W-1:0] cnt_r [3];
  logic [COUNT_W-1:0] cnt_nxt [3];
  logic [SUM_W-1:0]   sum_r [3];
  logic [SUM_W-1:0]   sum_nxt [3];
  logic [SUM_W-1:0]   sqs_r [3];
  logic [SUM_W-1:0]   sqs_nxt [3];
  logic [TICK_W-1:0]  min_r [3];
  logic [TICK_W-1:0]  min_nxt [3];
  logic [TICK_W-1:0]  max_r [3];
  logic [TICK_W-1:0]  max_nxt [3];

  // memory ports
  logic               ceil_we;
  logic [AW-1:0]      ceil_waddr;
  logic [TICK_W-1:0]  ceil_rd;
  logic               ep_we, tot_we, pe_we, pt_we;
  logic [AW-1:0]      ep_waddr, tot_waddr;
  logic [COUNT_W-1:0] ep_wdata, tot_wdata;
  logic [COUNT_W-1:0] ep_rd, tot_rd;
  logic [PCT_AW-1:0]  pct_waddr, pct_raddr;
  logic [TICK_W-1:0]  pct_wdata, pe_rd, pt_rd;

  logic               accept;
  logic [COUNT_W:0]   cnt_add;
  logic [COUNT_W-1:0] walk_cnt;
  logic [13:0]        mul_a, mul_b;
  logic [53:0]        lhs, rhs;
  logic               pct_pass;
  logic [COUNT_W:0]   sum41;
  logic [SUM_W:0]     s64a, s64b, s64c;
  logic [TICK_W-1:0]  pct_rd, stat_val;
  logic [1:0]         sc_idx;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  lhp_ram #(.DEPTH(BUCKET_CNT), .WIDTH(TICK_W)) u_ceil (
    .clk(clk), .we(ceil_we), .waddr(ceil_waddr), .wdata(in_req.ceiling_value),
    .raddr(idx_r), .rdata(ceil_rd)
  );
  lhp_ram #(.DEPTH(BUCKET_CNT), .WIDTH(COUNT_W)) u_ep (
    .clk(clk), .we(ep_we), .waddr(ep_waddr), .wdata(ep_wdata),
    .raddr(idx_r), .rdata(ep_rd)
  );
  lhp_ram #(.DEPTH(BUCKET_CNT), .WIDTH(COUNT_W)) u_tot (
    .clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
    .raddr(idx_r), .rdata(tot_rd)
  );
  lhp_ram #(.DEPTH(PCT_DEPTH), .WIDTH(TICK_W), .ADDR_W(PCT_AW)) u_pe (
    .clk(clk), .we(pe_we), .waddr(pct_waddr), .wdata(pct_wdata),
    .raddr(pct_raddr), .rdata(pe_rd)
  );
  lhp_ram #(.DEPTH(PCT_DEPTH), .WIDTH(TICK_W), .ADDR_W(PCT_AW)) u_pt (
    .clk(clk), .we(pt_we), .waddr(pct_waddr), .wdata(pct_wdata),
    .raddr(pct_raddr), .rdata(pt_rd)
  );

  // ceiling load
  assign ceil_we    = accept && (in_req.kind == KIND_LOAD) &&
                      (32'(in_req.bucket_index) < BUCKET_CNT);
  assign ceil_waddr = AW'(in_req.bucket_index);

  // percentile threshold test for the current slot
  always_comb begin
    if (p_r == SLOT_P999) begin
      mul_a = MUL_999;
      mul_b = MUL_1000;
    end else if (p_r == SLOT_P9999) begin
      mul_a = MUL_9999;
      mul_b = MUL_10000;
    end else begin
      mul_a = 14'(p_r);
      mul_b = MUL_PCT;
    end
  end
  assign lhs      = {40'd0, mul_a} * {14'd0, wc_r};
  assign rhs      = {40'd0, mul_b} * {14'd0, sub_r};
  assign pct_pass = (p_r <= SLOT_P9999) && (lhs <= rhs);

  assign walk_cnt = walk_tot_r ? tot_rd : ep_rd;

  // statistic slot and value
  always_comb begin
    if (sel_r < SEL_MAX) begin
      pct_raddr = sel_r;
    end else if (sel_r == SEL_P999) begin
      pct_raddr = SLOT_P999;
    end else if (sel_r == SEL_P9999) begin
      pct_raddr = SLOT_P9999;
    end else begin
      pct_raddr = '0;
    end
  end
  assign pct_rd = scope_r ? pt_rd : pe_rd;
  assign sc_idx = scope_r ? 2'(SC_ALL) : 2'(SC_LAST);
  always_comb begin
    if (sel_r == SEL_MIN) begin
      stat_val = min_r[sc_idx];
    end else if (sel_r == SEL_MAX) begin
      stat_val = max_r[sc_idx];
    end else if (sel_r inside {[SEL_MIN:SEL_P9999]}) begin
      stat_val = pct_rd;
    end else begin
      stat_val = '0;
    end
  end

  // sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    sub_nxt       = sub_r;
    wc_nxt        = wc_r;
    ceil_nxt      = ceil_r;
    walk_tot_nxt  = walk_tot_r;
    frozen_nxt    = frozen_r;
    ticks_nxt     = ticks_r;
    sq_nxt        = sq_r;
    sel_nxt       = sel_r;
    scope_nxt     = scope_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    sqs_nxt       = sqs_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    ep_we         = 1'b0;
    ep_waddr      = idx_r;
    ep_wdata      = '0;
    tot_we        = 1'b0;
    tot_waddr     = idx_r;
    tot_wdata     = '0;
    pe_we         = 1'b0;
    pt_we         = 1'b0;
    pct_waddr     = p_r;
    pct_wdata     = ceil_r;
    cnt_add       = '0;
    sum41         = '0;
    s64a          = '0;
    s64b          = '0;
    s64c          = '0;

    case (state_r)
      S_CLEAR: begin
        // zero the count and percentile memories
        ep_waddr  = clr_r[AW-1:0];
        tot_waddr = clr_r[AW-1:0];
        pct_waddr = clr_r[PCT_AW-1:0];
        pct_wdata = '0;
        ep_we     = (32'(clr_r) < BUCKET_CNT);
        tot_we    = ep_we;
        pe_we     = (32'(clr_r) < PCT_DEPTH);
        pt_we     = pe_we;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (in_req.kind)
            KIND_SAMPLE: begin
              // update open count, sum, min, max now; square lands later
              ticks_nxt = in_req.sample_ticks;
              sq_nxt    = {31'd0, in_req.sample_ticks} * {31'd0, in_req.sample_ticks};
              cnt_nxt[SC_OPEN] = (cnt_r[SC_OPEN] == COUNT_MAX) ? COUNT_MAX :
                                 cnt_r[SC_OPEN] + 1'b1;
              s64a = {1'b0, sum_r[SC_OPEN]} + 64'(in_req.sample_ticks);
              sum_nxt[SC_OPEN] = s64a[SUM_W] ? SUM_MAX : s64a[SUM_W-1:0];
              if (in_req.sample_ticks < min_r[SC_OPEN]) begin
                min_nxt[SC_OPEN] = in_req.sample_ticks;
              end
              if (in_req.sample_ticks > max_r[SC_OPEN]) begin
                max_nxt[SC_OPEN] = in_req.sample_ticks;
              end
              idx_nxt   = '0;
              state_nxt = S_SRCH_RD;
            end
            KIND_CLOSE: begin
              // fold open totals into all-time, copy to last, reset open, then walk the buckets
              sum41 = {1'b0, cnt_r[SC_ALL]} + {1'b0, cnt_r[SC_OPEN]};
              cnt_nxt[SC_ALL] = sum41[COUNT_W] ? COUNT_MAX : sum41[COUNT_W-1:0];
              s64b = {1'b0, sum_r[SC_ALL]} + {1'b0, sum_r[SC_OPEN]};
              sum_nxt[SC_ALL] = s64b[SUM_W] ? SUM_MAX : s64b[SUM_W-1:0];
              s64c = {1'b0, sqs_r[SC_ALL]} + {1'b0, sqs_r[SC_OPEN]};
              sqs_nxt[SC_ALL] = s64c[SUM_W] ? SUM_MAX : s64c[SUM_W-1:0];
              if (min_r[SC_OPEN] < min_r[SC_ALL]) begin
                min_nxt[SC_ALL] = min_r[SC_OPEN];
              end
              if (max_r[SC_OPEN] > max_r[SC_ALL]) begin
                max_nxt[SC_ALL] = max_r[SC_OPEN];
              end
              cnt_nxt[SC_LAST] = cnt_r[SC_OPEN];
              sum_nxt[SC_LAST] = sum_r[SC_OPEN];
              sqs_nxt[SC_LAST] = sqs_r[SC_OPEN];
              min_nxt[SC_LAST] = min_r[SC_OPEN];
              max_nxt[SC_LAST] = max_r[SC_OPEN];
              cnt_nxt[SC_OPEN] = '0;
              sum_nxt[SC_OPEN] = '0;
              sqs_nxt[SC_OPEN] = '0;
              min_nxt[SC_OPEN] = TICK_MAX;
              max_nxt[SC_OPEN] = '0;
              wc_nxt       = cnt_r[SC_OPEN];
              walk_tot_nxt = 1'b0;
              idx_nxt      = '0;
              p_nxt        = SLOT_FIRST;
              sub_nxt      = '0;
              state_nxt    = S_WALK_RD;
            end
            KIND_READ: begin
              sel_nxt   = in_req.statistic_select;
              scope_nxt = in_req.scope_all;
              if (in_req.scope_all && !frozen_r) begin
                // first all-time read: compute all-time percentiles once
                frozen_nxt   = 1'b1;
                wc_nxt       = cnt_r[SC_ALL];
                walk_tot_nxt = 1'b1;
                idx_nxt      = '0;
                p_nxt        = SLOT_FIRST;
                sub_nxt      = '0;
                state_nxt    = S_WALK_RD;
              end else begin
                state_nxt = S_STAT_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        // first bucket whose ceiling covers the sample, else the last one
        if (ceil_rd >= ticks_r || idx_r == IDX_LAST) begin
          state_nxt = S_INC_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SRCH_RD;
        end
      end

      S_INC_RD: begin
        state_nxt = S_INC_WR;
      end

      S_INC_WR: begin
        ep_we    = 1'b1;
        ep_wdata = (ep_rd == COUNT_MAX) ? COUNT_MAX : ep_rd + 1'b1;
        s64a = {1'b0, sqs_r[SC_OPEN]} + 64'(sq_r);
        sqs_nxt[SC_OPEN] = s64a[SUM_W] ? SUM_MAX : s64a[SUM_W-1:0];
        state_nxt = S_IDLE;
      end

      S_WALK_RD: begin
        state_nxt = S_WALK_LD;
      end

      S_WALK_LD: begin
        // advance the subtotal; on close, fold the bucket and clear it
        cnt_add  = {1'b0, sub_r} + {1'b0, walk_cnt};
        sub_nxt  = cnt_add[COUNT_W] ? COUNT_MAX : cnt_add[COUNT_W-1:0];
        ceil_nxt = ceil_rd;
        if (!walk_tot_r) begin
          sum41     = {1'b0, tot_rd} + {1'b0, ep_rd};
          tot_we    = 1'b1;
          tot_wdata = sum41[COUNT_W] ? COUNT_MAX : sum41[COUNT_W-1:0];
          ep_we     = 1'b1;
          ep_wdata  = '0;
        end
        state_nxt = S_WALK_TEST;
      end

      S_WALK_TEST: begin
        // record one reached percentile per cycle, else move on
        if (pct_pass) begin
          pe_we = !walk_tot_r;
          pt_we = walk_tot_r;
          p_nxt = p_r + 1'b1;
        end else if (idx_r == IDX_LAST) begin
          state_nxt = walk_tot_r ? S_STAT_RD : S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_WALK_RD;
        end
      end

      S_STAT_RD: begin
        state_nxt = S_STAT_OUT;
      end

      S_STAT_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_rsp_nxt.stat_ticks      = stat_val;
          out_rsp_nxt.sample_count    = cnt_r[sc_idx];
          out_rsp_nxt.tick_sum        = sum_r[sc_idx];
          out_rsp_nxt.tick_square_sum = sqs_r[sc_idx];
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      frozen_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < 3; s++) begin
        cnt_r[s] <= '0;
        sum_r[s] <= '0;
        sqs_r[s] <= '0;
        min_r[s] <= TICK_MAX;
        max_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      frozen_r    <= frozen_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      sqs_r       <= sqs_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    p_r        <= p_nxt;
    sub_r      <= sub_nxt;
    wc_r       <= wc_nxt;
    ceil_r     <= ceil_nxt;
    walk_tot_r <= walk_tot_nxt;
    ticks_r    <= ticks_nxt;
    sq_r       <= sq_nxt;
    sel_r      <= sel_nxt;
    scope_r    <= scope_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

endmodule
`default_nettype wire
